[src/sat_pkg.sv]
// Package for the summed-area table box-sum block.
// Holds field widths, register indexes, action codes and the sequencer state type.
// No dependencies.
`default_nettype none

package sat_pkg;

    // Field widths fixed by the word formats.
    localparam int COORD_W    = 8;
    localparam int PIX_PORT_W = 8;
    localparam int DIM_W      = 9;
    localparam int SUM_W      = 24;
    localparam int SQ_W       = 32;
    localparam int REG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Action codes of an input word.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_SQR,
        ST_LD_LEFT,
        ST_LD_WR,
        ST_Q_RD_A,
        ST_Q_RD_B,
        ST_Q_RD_C,
        ST_Q_RD_D,
        ST_Q_LAST
    } sat_state_t;

endpackage

`default_nettype wire

[src/sat_if.sv]
// Valid/ready channel interfaces for the summed-area table box-sum block.
// Depends on sat_pkg for the field widths.
`default_nettype none

// Input channel: one load or query word.
interface sat_item_if
    import sat_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [PIX_PORT_W-1:0] pixel;
    logic [COORD_W-1:0]    left_col;
    logic [COORD_W-1:0]    top_row;
    logic [COORD_W-1:0]    right_col;
    logic [COORD_W-1:0]    bottom_row;

    modport source (
        output valid, action, pixel, left_col, top_row, right_col, bottom_row,
        input  ready
    );
    modport sink (
        input  valid, action, pixel, left_col, top_row, right_col, bottom_row,
        output ready
    );
endinterface

// Output channel: one query result word.
interface sat_result_if
    import sat_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] box_sum;
    logic [SQ_W-1:0]  box_sum_sq;
    logic             query_error;

    modport source (
        output valid, box_sum, box_sum_sq, query_error,
        input  ready
    );
    modport sink (
        input  valid, box_sum, box_sum_sq, query_error,
        output ready
    );
endinterface

`default_nettype wire

[src/summed_area_table_box_sum.sv]
// Top level of the summed-area table box-sum block: sequencer, shared add/subtract
// unit and the two single-port table memories. Depends on sat_pkg and sat_if.
//
// Usage. Words arrive on the item channel (valid/ready). A load word (action 0)
// writes the next pixel of the image in raster order into the sum and square
// tables; it produces no result. A query word (action 1) returns one word on the
// result channel with the inclusive rectangle's sum and sum of squares, or an
// error flag with zero sums if the load is unfinished, the corners are reversed
// or a corner lies outside the image. The image size is set through the write
// port (index 0 width, index 1 height); a write restarts the load.
// Timing. One word is in progress at a time and item.ready is high only while
// the sequencer is idle. A load does one multiply, one read of the entry above,
// then two passes through the shared adder and the write. A query makes four
// corner reads through the single memory port before the output register, each
// folded in by the shared adder in the step after its read. A query that fails
// its checks goes from the accept straight to the last step.
// Stalls. The result sits in an output register, so the next word is accepted
// while it waits; a query that finishes while the register is still full holds
// in its last step until the receiver takes the waiting word.
// Reset. Reset sets both dimensions to 256 (or the maximum if smaller) and
// restarts the load. Table contents are not cleared; queries are refused
// until a full image has been loaded.
`default_nettype none

module summed_area_table_box_sum
    import sat_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [DIM_W-1:0]     wr_data,
    sat_item_if.sink                  item,
    sat_result_if.source              result
);

    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int PIX_W      = (PIXEL_BITS < PIX_PORT_W) ? PIXEL_BITS : PIX_PORT_W;
    localparam int SQP_W      = 2 * PIX_W;
    localparam int WIDTH_RST  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int HEIGHT_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    // Table entry address: row-major with a fixed pitch of MAX_WIDTH.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] row,
                                                    input logic [DIM_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction

    // Saturate a written dimension into 1..lim.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int lim);
        if (v == '0)
        begin
            return DIM_W'(1);
        end
        else if (int'(v) > lim)
        begin
            return DIM_W'(lim);
        end
        return v;
    endfunction

    // Table memories.
    logic [SUM_W-1:0] sum_mem [0:DEPTH-1];
    logic [SQ_W-1:0]  sq_mem  [0:DEPTH-1];

    sat_state_t         state_reg, state_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic               ready_reg, ready_next;
    logic [SUM_W-1:0]   left_sum_reg, left_sum_next;
    logic [SQ_W-1:0]    left_sq_reg, left_sq_next;
    logic [PIX_W-1:0]   pix_reg, pix_next;
    logic [SQP_W-1:0]   sq_reg, sq_next;
    logic [COORD_W-1:0] x0_reg, x0_next;
    logic [COORD_W-1:0] y0_reg, y0_next;
    logic [COORD_W-1:0] x1_reg, x1_next;
    logic [COORD_W-1:0] y1_reg, y1_next;
    logic               err_reg, err_next;
    logic [SUM_W-1:0]   acc_sum_reg, acc_sum_next;
    logic [SQ_W-1:0]    acc_sq_reg, acc_sq_next;
    logic               out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]   out_sum_reg, out_sum_next;
    logic [SQ_W-1:0]    out_sq_reg, out_sq_next;
    logic               out_err_reg, out_err_next;
    logic [SUM_W-1:0]   rd_sum_reg;
    logic [SQ_W-1:0]    rd_sq_reg;

    logic               accept;
    logic               query_bad;
    logic               out_free;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ADDR_W-1:0]  up_addr, cur_addr;
    logic [ADDR_W-1:0]  addr_a, addr_b, addr_c, addr_d;
    logic [COORD_W-1:0] x0_m1, y0_m1;
    logic [DIM_W-1:0]   row_m1;

    // Shared add/subtract unit, one lane per table.
    logic               alu_sub;
    logic [SUM_W-1:0]   alu_a_sum, alu_b_sum, alu_sum;
    logic [SQ_W-1:0]    alu_a_sq, alu_b_sq, alu_sq;

    assign alu_sum = alu_sub ? (alu_a_sum - alu_b_sum) : (alu_a_sum + alu_b_sum);
    assign alu_sq  = alu_sub ? (alu_a_sq - alu_b_sq) : (alu_a_sq + alu_b_sq);

    // Handshake and query checks.
    assign item.ready  = (state_reg == ST_IDLE);
    assign accept      = item.valid && (state_reg == ST_IDLE);
    assign out_free    = !out_valid_reg || result.ready;
    assign query_bad   = !ready_reg
                       || (item.left_col > item.right_col)
                       || (item.top_row > item.bottom_row)
                       || ({1'b0, item.right_col} >= width_reg)
                       || ({1'b0, item.bottom_row} >= height_reg);

    // Corner and load addresses; a coordinate of zero has no predecessor.
    assign x0_m1    = (x0_reg == '0) ? '0 : x0_reg - COORD_W'(1);
    assign y0_m1    = (y0_reg == '0) ? '0 : y0_reg - COORD_W'(1);
    assign row_m1   = (row_reg == '0) ? '0 : row_reg - DIM_W'(1);
    assign up_addr  = cell_addr(row_m1, col_reg);
    assign cur_addr = cell_addr(row_reg, col_reg);
    assign addr_a   = cell_addr({1'b0, y1_reg}, {1'b0, x1_reg});
    assign addr_b   = cell_addr({1'b0, y1_reg}, {1'b0, x0_m1});
    assign addr_c   = cell_addr({1'b0, y0_m1}, {1'b0, x1_reg});
    assign addr_d   = cell_addr({1'b0, y0_m1}, {1'b0, x0_m1});

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.action == ACT_LOAD)
                    begin
                        state_next = ST_LD_SQR;
                    end
                    else if (query_bad)
                    begin
                        state_next = ST_Q_LAST;
                    end
                    else
                    begin
                        state_next = ST_Q_RD_A;
                    end
                end
            end
            ST_LD_SQR:  state_next = ST_LD_LEFT;
            ST_LD_LEFT: state_next = ST_LD_WR;
            ST_LD_WR:   state_next = ST_IDLE;
            ST_Q_RD_A:  state_next = ST_Q_RD_B;
            ST_Q_RD_B:  state_next = ST_Q_RD_C;
            ST_Q_RD_C:  state_next = ST_Q_RD_D;
            ST_Q_RD_D:  state_next = ST_Q_LAST;
            ST_Q_LAST:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath control for each step of the sequencer.
    always_comb
    begin
        width_next     = width_reg;
        height_next    = height_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        ready_next     = ready_reg;
        left_sum_next  = left_sum_reg;
        left_sq_next   = left_sq_reg;
        pix_next       = pix_reg;
        sq_next        = sq_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        err_next       = err_reg;
        acc_sum_next   = acc_sum_reg;
        acc_sq_next    = acc_sq_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_sum_next   = out_sum_reg;
        out_sq_next    = out_sq_reg;
        out_err_next   = out_err_reg;
        mem_we         = 1'b0;
        mem_addr       = cur_addr;
        alu_sub        = 1'b0;
        alu_a_sum      = '0;
        alu_b_sum      = '0;
        alu_a_sq       = '0;
        alu_b_sq       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pix_next = item.pixel[PIX_W-1:0];
                    x0_next  = item.left_col;
                    y0_next  = item.top_row;
                    x1_next  = item.right_col;
                    y1_next  = item.bottom_row;
                    err_next = query_bad;
                    // A load after a finished image starts a new one.
                    if (item.action == ACT_LOAD && ready_reg)
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        ready_next = 1'b0;
                    end
                end
            end
            ST_LD_SQR:
            begin
                sq_next  = pix_reg * pix_reg;
                mem_addr = up_addr;
            end
            ST_LD_LEFT:
            begin
                // Running row sums restart at the first column.
                mem_addr      = up_addr;
                alu_a_sum     = (col_reg == '0) ? '0 : left_sum_reg;
                alu_a_sq      = (col_reg == '0) ? '0 : left_sq_reg;
                alu_b_sum     = SUM_W'(pix_reg);
                alu_b_sq      = SQ_W'(sq_reg);
                left_sum_next = alu_sum;
                left_sq_next  = alu_sq;
            end
            ST_LD_WR:
            begin
                // Entry is the row sum plus the entry above it.
                mem_addr  = cur_addr;
                mem_we    = 1'b1;
                alu_a_sum = left_sum_reg;
                alu_a_sq  = left_sq_reg;
                alu_b_sum = (row_reg == '0) ? '0 : rd_sum_reg;
                alu_b_sq  = (row_reg == '0) ? '0 : rd_sq_reg;
                if (col_reg + DIM_W'(1) >= width_reg)
                begin
                    col_next = '0;
                    if (row_reg + DIM_W'(1) >= height_reg)
                    begin
                        row_next   = '0;
                        ready_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + DIM_W'(1);
                end
            end
            ST_Q_RD_A:
            begin
                mem_addr = addr_a;
            end
            ST_Q_RD_B:
            begin
                mem_addr     = addr_b;
                alu_b_sum    = rd_sum_reg;
                alu_b_sq     = rd_sq_reg;
                acc_sum_next = alu_sum;
                acc_sq_next  = alu_sq;
            end
            ST_Q_RD_C:
            begin
                mem_addr     = addr_c;
                alu_sub      = 1'b1;
                alu_a_sum    = acc_sum_reg;
                alu_a_sq     = acc_sq_reg;
                alu_b_sum    = (x0_reg == '0) ? '0 : rd_sum_reg;
                alu_b_sq     = (x0_reg == '0) ? '0 : rd_sq_reg;
                acc_sum_next = alu_sum;
                acc_sq_next  = alu_sq;
            end
            ST_Q_RD_D:
            begin
                mem_addr     = addr_d;
                alu_sub      = 1'b1;
                alu_a_sum    = acc_sum_reg;
                alu_a_sq     = acc_sq_reg;
                alu_b_sum    = (y0_reg == '0) ? '0 : rd_sum_reg;
                alu_b_sq     = (y0_reg == '0) ? '0 : rd_sq_reg;
                acc_sum_next = alu_sum;
                acc_sq_next  = alu_sq;
            end
            ST_Q_LAST:
            begin
                // Upper-left corner is added back only when both edges are inside.
                mem_addr  = addr_d;
                alu_a_sum = acc_sum_reg;
                alu_a_sq  = acc_sq_reg;
                if (x0_reg != '0 && y0_reg != '0)
                begin
                    alu_b_sum = rd_sum_reg;
                    alu_b_sq  = rd_sq_reg;
                end
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = err_reg ? '0 : alu_sum;
                    out_sq_next    = err_reg ? '0 : alu_sq;
                    out_err_next   = err_reg;
                end
            end
            default:
            begin
                mem_addr = cur_addr;
            end
        endcase

        // Register writes restart the load.
        if (wr_en)
        begin
            case (wr_index)
                REG_IMAGE_WIDTH:  width_next  = clamp_dim(wr_data, MAX_WIDTH);
                REG_IMAGE_HEIGHT: height_next = clamp_dim(wr_data, MAX_HEIGHT);
                default:          width_next  = width_reg;
            endcase
            col_next      = '0;
            row_next      = '0;
            ready_next    = 1'b0;
            left_sum_next = '0;
            left_sq_next  = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= DIM_W'(WIDTH_RST);
            height_reg    <= DIM_W'(HEIGHT_RST);
            col_reg       <= '0;
            row_reg       <= '0;
            ready_reg     <= 1'b0;
            left_sum_reg  <= '0;
            left_sq_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            ready_reg     <= ready_next;
            left_sum_reg  <= left_sum_next;
            left_sq_reg   <= left_sq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pix_reg     <= pix_next;
        sq_reg      <= sq_next;
        x0_reg      <= x0_next;
        y0_reg      <= y0_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        err_reg     <= err_next;
        acc_sum_reg <= acc_sum_next;
        acc_sq_reg  <= acc_sq_next;
        out_sum_reg <= out_sum_next;
        out_sq_reg  <= out_sq_next;
        out_err_reg <= out_err_next;
    end

    // Single-port table memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[mem_addr] <= alu_sum;
            sq_mem[mem_addr]  <= alu_sq;
        end
        rd_sum_reg <= sum_mem[mem_addr];
        rd_sq_reg  <= sq_mem[mem_addr];
    end

    // Result channel.
    assign result.valid       = out_valid_reg;
    assign result.box_sum     = out_sum_reg;
    assign result.box_sum_sq  = out_sq_reg;
    assign result.query_error = out_err_reg;

    // A new result word is only ever loaded from the last query step.
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_Q_LAST))
        else $error("result word appeared outside the last query step");

    // The table becomes ready only as the last pixel of an image is written.
    a_ready_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_reg) |-> $past(state_reg == ST_LD_WR))
        else $error("table marked ready without a final pixel write");

    // The load position never leaves the configured image.
    a_load_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg < width_reg) && (row_reg < height_reg))
        else $error("load position outside the image");

    // A flagged query carries zero sums.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_sum_reg == '0 && out_sq_reg == '0))
        else $error("error result with non-zero sums");

    // A load word never produces a result word.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LD_WR) |=> !$rose(out_valid_reg))
        else $error("load produced a result word");

endmodule

`default_nettype wire

[tb/sat_box_sum_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the summed-area table box-sum block: watches the write port and both
// word channels, keeps its own copy of the two tables and checks every result word.
// Depends on sat_pkg and on the sat_item_if and sat_result_if interfaces.

module sat_box_sum_checker
    import sat_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [DIM_W-1:0]     wr_data,
    sat_item_if                       item_ch,
    sat_result_if                     result_ch,
    output int                        fail_count,
    output int                        outstanding
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    typedef struct packed {
        logic [SUM_W-1:0] box_sum;
        logic [SQ_W-1:0]  box_sum_sq;
        logic             query_error;
    } box_word_t;

    // Shadow tables and load position; entries are indexed row * MAX_WIDTH + column.
    logic [SUM_W-1:0] sum_tab [DEPTH];
    logic [SQ_W-1:0]  sq_tab  [DEPTH];
    int unsigned      img_cols;
    int unsigned      img_rows;
    int unsigned      next_col;
    int unsigned      next_row;
    logic             image_done;
    logic [SUM_W-1:0] row_sum;
    logic [SQ_W-1:0]  row_sq;
    box_word_t        box_words_due [$];

    // A dimension register saturates into 1..limit.
    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] code, int unsigned limit);
        int unsigned v;
        v = 32'(code);
        if (v == 0)
        begin
            return 1;
        end
        if (v > limit)
        begin
            return limit;
        end
        return v;
    endfunction

    // Any register write, and a load after a finished image, starts a fresh image.
    function automatic void restart_image();
        next_col   = 0;
        next_row   = 0;
        image_done = 1'b0;
        row_sum    = '0;
        row_sq     = '0;
    endfunction

    // A load adds the running row sum to the entry directly above.
    function automatic void add_pixel(logic [PIX_PORT_W-1:0] pix);
        logic [SQ_W-1:0]  p;
        logic [SUM_W-1:0] up_sum;
        logic [SQ_W-1:0]  up_sq;
        int unsigned      at;
        p      = SQ_W'(pix) & ((SQ_W'(1) << PIXEL_BITS) - SQ_W'(1));
        up_sum = '0;
        up_sq  = '0;
        if (image_done)
        begin
            restart_image();
        end
        if (next_col == 0)
        begin
            row_sum = '0;
            row_sq  = '0;
        end
        row_sum = row_sum + p[SUM_W-1:0];
        row_sq  = row_sq + p * p;
        if (next_row > 0)
        begin
            at     = (next_row - 1) * MAX_WIDTH + next_col;
            up_sum = sum_tab[at];
            up_sq  = sq_tab[at];
        end
        at          = next_row * MAX_WIDTH + next_col;
        sum_tab[at] = row_sum + up_sum;
        sq_tab[at]  = row_sq + up_sq;
        next_col++;
        if (next_col >= img_cols)
        begin
            next_col = 0;
            next_row++;
            if (next_row >= img_rows)
            begin
                next_row   = 0;
                image_done = 1'b1;
            end
        end
    endfunction

    // Rectangle sums from up to four corners; the modular wrap at each width is exact.
    function automatic box_word_t rect_sums(int unsigned x0, int unsigned y0,
                                            int unsigned x1, int unsigned y1);
        box_word_t   sums;
        int unsigned at;
        sums = '0;
        if (!image_done || x0 > x1 || y0 > y1 || x1 >= img_cols || y1 >= img_rows)
        begin
            sums.query_error = 1'b1;
            return sums;
        end
        at              = y1 * MAX_WIDTH + x1;
        sums.box_sum    = sum_tab[at];
        sums.box_sum_sq = sq_tab[at];
        if (x0 > 0)
        begin
            at              = y1 * MAX_WIDTH + x0 - 1;
            sums.box_sum    -= sum_tab[at];
            sums.box_sum_sq -= sq_tab[at];
        end
        if (y0 > 0)
        begin
            at              = (y0 - 1) * MAX_WIDTH + x1;
            sums.box_sum    -= sum_tab[at];
            sums.box_sum_sq -= sq_tab[at];
        end
        if (x0 > 0 && y0 > 0)
        begin
            at              = (y0 - 1) * MAX_WIDTH + x0 - 1;
            sums.box_sum    += sum_tab[at];
            sums.box_sum_sq += sq_tab[at];
        end
        return sums;
    endfunction

    function automatic bit field_ok(string name, logic [SQ_W-1:0] want, logic [SQ_W-1:0] got);
        if (got === want)
        begin
            return 1'b1;
        end
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        return 1'b0;
    endfunction

    // Configuration, result comparison and prediction, all on the same clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        box_word_t want;
        bit        bad;
        if (!rst_n)
        begin
            img_cols = clamp_dim(9'd256, MAX_WIDTH);
            img_rows = clamp_dim(9'd256, MAX_HEIGHT);
            restart_image();
            box_words_due.delete();
            fail_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == REG_IMAGE_WIDTH)
                begin
                    img_cols = clamp_dim(wr_data, MAX_WIDTH);
                    restart_image();
                end
                else if (wr_index == REG_IMAGE_HEIGHT)
                begin
                    img_rows = clamp_dim(wr_data, MAX_HEIGHT);
                    restart_image();
                end
            end

            if (result_ch.valid && result_ch.ready)
            begin
                if (box_words_due.size() == 0)
                begin
                    $display("%0t: expected no result word, got sum %0d, sum_sq %0d, error %0b",
                             $time, result_ch.box_sum, result_ch.box_sum_sq,
                             result_ch.query_error);
                    fail_count++;
                end
                else
                begin
                    want = box_words_due.pop_front();
                    bad  = !field_ok("box_sum", SQ_W'(want.box_sum), SQ_W'(result_ch.box_sum))
                         | !field_ok("box_sum_sq", want.box_sum_sq, result_ch.box_sum_sq)
                         | !field_ok("query_error", SQ_W'(want.query_error),
                                     SQ_W'(result_ch.query_error));
                    if (bad)
                    begin
                        fail_count++;
                    end
                end
            end

            if (item_ch.valid && item_ch.ready)
            begin
                if (item_ch.action == ACT_LOAD)
                begin
                    add_pixel(item_ch.pixel);
                end
                else
                begin
                    box_words_due.insert(box_words_due.size(),
                                         rect_sums(32'(item_ch.left_col), 32'(item_ch.top_row),
                                                   32'(item_ch.right_col),
                                                   32'(item_ch.bottom_row)));
                end
            end
            outstanding <= box_words_due.size();
        end
    end

endmodule

[tb/tb_summed_area_table_box_sum.sv]
`timescale 1ns / 100ps
// Testbench top for the summed-area table box-sum block: clock, reset, register writes,
// bursty load and query words, a stalling result receiver and the verdict.
// Depends on sat_pkg, sat_if, summed_area_table_box_sum and sat_box_sum_checker.

module tb_summed_area_table_box_sum;
    import sat_pkg::*;

    localparam int RANDOM_WORDS  = 400;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int DIM_MAX       = 256;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [DIM_W-1:0]     wr_data;
    logic                 hold_req = 1'b0;
    int                   fail_count;
    int                   outstanding;
    int                   words_sent;
    int                   burst_left;
    int unsigned          cycle_count;

    sat_item_if   item_ch ();
    sat_result_if result_ch ();

    summed_area_table_box_sum i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .item     (item_ch),
        .result   (result_ch)
    );

    sat_box_sum_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .item_ch     (item_ch),
        .result_ch   (result_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Register write, after which wr_en is driven low before the task returns so that writes never abut.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one word and waits for the handshake; bursts may end in a random gap.
    task automatic offer(input logic act, input logic [PIX_PORT_W-1:0] pix,
                         input logic [COORD_W-1:0] x0, input logic [COORD_W-1:0] y0,
                         input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1);
        int gap;
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.pixel      <= pix;
        item_ch.left_col   <= x0;
        item_ch.top_row    <= y0;
        item_ch.right_col  <= x1;
        item_ch.bottom_row <= y1;
        do @(posedge clk); while (!item_ch.ready);
        words_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(20, 1);
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Waits until every query has been answered and any load in flight has finished.
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIX_PORT_W-1:0] pick_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return PIX_PORT_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] small_dim(input int unsigned top);
        return ($urandom_range(9) == 0) ? '0 : DIM_W'($urandom_range(top, 1));
    endfunction

    // Unused fields of each word carry random bits.
    task automatic load_pixel(input logic [PIX_PORT_W-1:0] pix);
        offer(ACT_LOAD, pix, COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic ask(input int unsigned x0, input int unsigned y0,
                       input int unsigned x1, input int unsigned y1);
        offer(ACT_QUERY, PIX_PORT_W'($urandom), COORD_W'(x0), COORD_W'(y0),
              COORD_W'(x1), COORD_W'(y1));
    endtask

    task automatic inner_query(input int unsigned w, input int unsigned h);
        int unsigned x0, y0, x1, y1;
        x1 = $urandom_range(w - 1, 0);
        x0 = $urandom_range(x1, 0);
        y1 = $urandom_range(h - 1, 0);
        y0 = $urandom_range(y1, 0);
        ask(x0, y0, x1, y1);
    endtask

    // Malformed rectangles: anywhere, reversed, or just past the image edge.
    task automatic odd_query(input int unsigned w, input int unsigned h);
        int unsigned x0, y0, x1, y1;
        x0 = $urandom_range(255);
        y0 = $urandom_range(255);
        x1 = $urandom_range(255);
        y1 = $urandom_range(255);
        case ($urandom_range(3))
            1:
            begin
                if (w > 1)
                begin
                    x1 = $urandom_range(w - 2, 0);
                    x0 = $urandom_range(w - 1, x1 + 1);
                    y0 = 0;
                    y1 = h - 1;
                end
            end
            2:
            begin
                if (h > 1)
                begin
                    y1 = $urandom_range(h - 2, 0);
                    y0 = $urandom_range(h - 1, y1 + 1);
                    x0 = 0;
                    x1 = w - 1;
                end
            end
            3:
            begin
                if (w < DIM_MAX)
                begin
                    x0 = 0;
                    x1 = w;
                    y0 = 0;
                    y1 = $urandom_range(h - 1, 0);
                end
            end
            default:
            begin
                // Fully random corners, nearly always outside the image.
            end
        endcase
        ask(x0, y0, x1, y1);
    endtask

    // One image: set its size, load it with stray queries mixed in, query it, and
    // sometimes start a new image part way before asking again.
    task automatic run_phase(input logic [DIM_W-1:0] width_code,
                             input logic [DIM_W-1:0] height_code, input bit hold);
        int unsigned w, h;
        w = (width_code == 0) ? 1 : ((width_code > DIM_MAX) ? DIM_MAX : width_code);
        h = (height_code == 0) ? 1 : ((height_code > DIM_MAX) ? DIM_MAX : height_code);
        settle();
        if ($urandom_range(1) == 1)
        begin
            write_reg(REG_IMAGE_WIDTH, width_code);
            write_reg(REG_IMAGE_HEIGHT, height_code);
        end
        else
        begin
            write_reg(REG_IMAGE_HEIGHT, height_code);
            write_reg(REG_IMAGE_WIDTH, width_code);
        end
        repeat (w * h)
        begin
            if ($urandom_range(15) == 0)
            begin
                inner_query(w, h);
            end
            load_pixel(pick_pixel());
        end
        if (hold)
        begin
            hold_req = 1'b1;
        end
        ask(0, 0, w - 1, h - 1);
        repeat ($urandom_range(12, 3))
        begin
            if ($urandom_range(4) == 0)
            begin
                odd_query(w, h);
            end
            else
            begin
                inner_query(w, h);
            end
        end
        if ($urandom_range(3) == 0)
        begin
            repeat ($urandom_range(w * h, 1)) load_pixel(pick_pixel());
            inner_query(w, h);
        end
    endtask

    // Result receiver: runs of steady, light or heavy stalling, and one long hold-off.
    initial
    begin : result_sink
        int run_left;
        int mode;
        bit hold_served;
        result_ch.ready <= 1'b0;
        run_left    = 0;
        mode        = 0;
        hold_served = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_served)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served = 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(40, 8);
                    mode     = $urandom_range(3);
                end
                run_left--;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(1) == 0);
                    2:       result_ch.ready <= ($urandom_range(3) != 0);
                    default: result_ch.ready <= ($urandom_range(3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("summed_area_table_box_sum verification failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n              <= 1'b0;
        wr_en              <= 1'b0;
        wr_index           <= REG_IMAGE_WIDTH;
        wr_data            <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.action     <= ACT_LOAD;
        item_ch.pixel      <= '0;
        item_ch.left_col   <= '0;
        item_ch.top_row    <= '0;
        item_ch.right_col  <= '0;
        item_ch.bottom_row <= '0;
        burst_left = 0;
        words_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Nothing loaded yet, so the query is refused.
        ask(0, 0, 0, 0);

        // Single-pixel image; a width of zero saturates to one column.
        settle();
        write_reg(REG_IMAGE_WIDTH, 9'd0);
        write_reg(REG_IMAGE_HEIGHT, 9'd1);
        load_pixel(8'hFF);
        ask(0, 0, 0, 0);
        ask(0, 0, 1, 0);
        load_pixel(8'h00);
        ask(0, 0, 0, 0);

        // Three by two image, with a query while the load is still unfinished.
        settle();
        write_reg(REG_IMAGE_WIDTH, 9'd3);
        write_reg(REG_IMAGE_HEIGHT, 9'd2);
        load_pixel(8'd255);
        load_pixel(8'd0);
        load_pixel(8'd170);
        ask(0, 0, 2, 0);
        load_pixel(8'd85);
        load_pixel(8'd1);
        load_pixel(8'd254);
        ask(0, 0, 2, 1);
        ask(1, 1, 2, 1);
        ask(1, 0, 2, 0);
        ask(0, 1, 0, 1);
        ask(2, 0, 1, 1);
        ask(0, 1, 2, 0);
        ask(255, 255, 255, 255);
        // A load after completion begins a new image and clears the ready state.
        load_pixel(8'd7);
        ask(0, 0, 0, 0);

        // Widest row, with the width written beyond the maximum.
        run_phase(9'd511, 9'd1, 1'b0);

        run_phase(small_dim(8), small_dim(6), 1'b1);
        while (words_sent < RANDOM_WORDS)
        begin
            run_phase(small_dim(10), small_dim(8), 1'b0);
        end

        settle();
        if (fail_count == 0)
        begin
            $display("summed_area_table_box_sum verification clean");
        end
        else
        begin
            $display("summed_area_table_box_sum verification failed");
        end
        $finish;
    end

endmodule
